[hdl/math_expression_lexer_unit_assert.svh]
`ifndef MATH_EXPRESSION_LEXER_UNIT_ASSERT_SVH
`define MATH_EXPRESSION_LEXER_UNIT_ASSERT_SVH

// same-cycle implication on clk, off while rst_n is low
`define MEL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication on clk, off while rst_n is low
`define MEL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/mel_pkg.sv]
package mel_pkg;

  localparam int unsigned MAX_STEPS = 8;
  localparam int unsigned STEP_W    = $clog2(MAX_STEPS);
  localparam int unsigned NPRIM     = 9;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    KIND_APPEND    = 2'd0,
    KIND_TOKEN_END = 2'd1,
    KIND_ERROR     = 2'd2,
    KIND_DONE      = 2'd3
  } kind_t;

  typedef logic [3:0] cls_t;
  typedef logic [2:0] lstate_t;
  typedef logic [3:0] prim_t;
  typedef logic [4:0] act_t;

  localparam cls_t CLS_ALPHA = 4'd0;
  localparam cls_t CLS_DIGIT = 4'd1;
  localparam cls_t CLS_WS    = 4'd2;
  localparam cls_t CLS_DOT   = 4'd3;
  localparam cls_t CLS_LPAR  = 4'd4;
  localparam cls_t CLS_RPAR  = 4'd5;
  localparam cls_t CLS_OP    = 4'd6;
  localparam cls_t CLS_EQ    = 4'd7;
  localparam cls_t CLS_SEMI  = 4'd8;
  localparam cls_t CLS_COMMA = 4'd9;
  localparam cls_t CLS_BAD   = 4'd10;

  localparam lstate_t ST_START  = 3'd0;
  localparam lstate_t ST_LAST   = 3'd5;
  localparam lstate_t NX_FORBID = 3'd7;

  localparam prim_t PRIM_NONE   = 4'd0;
  localparam prim_t PRIM_APPEND = 4'd1;
  localparam prim_t PRIM_CLOSE  = 4'd2;

  localparam act_t ACT_SEQ_LO = 5'd10;
  localparam act_t ACT_SEQ_HI = 5'd23;

  localparam logic [7:0] CH_US    = 8'h5F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic [2:0] ttype;
  } step_t;

  typedef struct packed {
    logic [STEP_W:0]              cnt;
    step_t [MAX_STEPS-1:0]        steps;
  } entry_t;

  localparam lstate_t NEXT_TAB [10][6] = '{
    '{3'd0, 3'd2, 3'd2, 3'd7, 3'd2, 3'd7},
    '{3'd7, 3'd5, 3'd2, 3'd7, 3'd5, 3'd5},
    '{3'd0, 3'd1, 3'd3, 3'd3, 3'd1, 3'd1},
    '{3'd7, 3'd5, 3'd7, 3'd7, 3'd5, 3'd5},
    '{3'd7, 3'd1, 3'd1, 3'd1, 3'd1, 3'd7},
    '{3'd7, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1},
    '{3'd7, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4},
    '{3'd1, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7},
    '{3'd7, 3'd0, 3'd0, 3'd0, 3'd7, 3'd0},
    '{3'd7, 3'd1, 3'd1, 3'd7, 3'd7, 3'd1}};

  localparam act_t ACT_TAB [10][6] = '{
    '{5'd1,  5'd1,  5'd1,  5'd0,  5'd10, 5'd0},
    '{5'd0,  5'd1,  5'd1,  5'd0,  5'd10, 5'd1},
    '{5'd0,  5'd0,  5'd0,  5'd0,  5'd5,  5'd4},
    '{5'd0,  5'd1,  5'd0,  5'd0,  5'd10, 5'd1},
    '{5'd0,  5'd11, 5'd12, 5'd12, 5'd13, 5'd0},
    '{5'd0,  5'd11, 5'd14, 5'd14, 5'd13, 5'd15},
    '{5'd0,  5'd1,  5'd16, 5'd16, 5'd1,  5'd19},
    '{5'd6,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0},
    '{5'd0,  5'd17, 5'd18, 5'd18, 5'd0,  5'd20},
    '{5'd0,  5'd21, 5'd22, 5'd0,  5'd0,  5'd23}};

  localparam prim_t SEQ_TAB [14][3] = '{
    '{4'd5, 4'd1, 4'd0}, '{4'd1, 4'd7, 4'd0}, '{4'd2, 4'd1, 4'd7},
    '{4'd5, 4'd1, 4'd7}, '{4'd3, 4'd1, 4'd7}, '{4'd4, 4'd1, 4'd7},
    '{4'd3, 4'd1, 4'd0}, '{4'd1, 4'd8, 4'd0}, '{4'd3, 4'd1, 4'd8},
    '{4'd4, 4'd1, 4'd0}, '{4'd4, 4'd1, 4'd8}, '{4'd1, 4'd9, 4'd0},
    '{4'd3, 4'd1, 4'd9}, '{4'd4, 4'd1, 4'd9}};

  function automatic cls_t char_class(logic [7:0] c);
    cls_t r;
    r = CLS_BAD;
    if (c inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_US})  r = CLS_ALPHA;
    else if (c inside {[8'h30:8'h39]})                 r = CLS_DIGIT;
    else if (c inside {8'h20, 8'h09, 8'h0D, 8'h0A})     r = CLS_WS;
    else if (c == CH_DOT)                              r = CLS_DOT;
    else if (c == 8'h28)                               r = CLS_LPAR;
    else if (c == 8'h29)                               r = CLS_RPAR;
    else if (c inside {8'h2B, 8'h2D, 8'h2A, 8'h2F})     r = CLS_OP;
    else if (c == CH_EQ)                               r = CLS_EQ;
    else if (c == CH_SEMI)                             r = CLS_SEMI;
    else if (c == CH_COMMA)                            r = CLS_COMMA;
    return r;
  endfunction

  // action code to up to three primitive steps
  function automatic logic [2:0][3:0] act_prims(act_t code);
    logic [2:0][3:0] p;
    act_t            off;
    p   = '0;
    off = code - ACT_SEQ_LO;
    if (code < ACT_SEQ_LO) begin
      p[0] = code[3:0];
    end else if (code <= ACT_SEQ_HI) begin
      for (int i = 0; i < 3; i++) p[i] = SEQ_TAB[off[3:0]][i];
    end
    return p;
  endfunction

  function automatic step_t prim_step(prim_t p, logic [7:0] c);
    step_t s;
    prim_t t;
    t = p - PRIM_CLOSE;
    if (p == PRIM_APPEND) begin
      s.kind  = KIND_APPEND;
      s.ch    = c;
      s.ttype = 3'd0;
    end else begin
      s.kind  = KIND_TOKEN_END;
      s.ch    = 8'd0;
      s.ttype = t[2:0];
    end
    return s;
  endfunction

endpackage

[hdl/mel_ifs.sv]
interface mel_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  modport source (output valid, ch, last, input ready);
  modport sink   (input valid, ch, last, output ready);
endinterface

interface mel_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_char;
  logic [2:0] token_type;
  logic       last_of_run;
  modport source (output valid, kind, out_char, token_type, last_of_run, input ready);
  modport sink   (input valid, kind, out_char, token_type, last_of_run, output ready);
endinterface

[hdl/mel_front.sv]
module mel_front
  import mel_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mel_in_if.sink     in_ch,
  input  logic       q_full,
  output logic       push,
  output entry_t     wentry
);

  lstate_t lex_state_r, lex_state_nxt;
  logic    hold_r, hold_nxt;

  lstate_t st, nx, nx_s;
  cls_t    cls;
  act_t    a_main;
  logic    accept;
  logic [2:0][3:0] pm, pw, ps;
  prim_t      pp [NPRIM];
  logic [7:0] pc [NPRIM];
  logic [STEP_W:0] n;
  step_t [MAX_STEPS-1:0] steps;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    st     = (lex_state_r > ST_LAST) ? ST_START : lex_state_r;
    cls    = char_class(in_ch.ch);
    nx     = (cls == CLS_BAD) ? NX_FORBID : NEXT_TAB[cls][st];
    nx_s   = (nx == NX_FORBID) ? ST_START : nx;
    a_main = (cls == CLS_BAD) ? act_t'(0) : ACT_TAB[cls][st];
    pm     = act_prims(a_main);
    pw     = in_ch.last ? act_prims(ACT_TAB[CLS_WS][nx_s])   : '0;
    ps     = in_ch.last ? act_prims(ACT_TAB[CLS_SEMI][nx_s]) : '0;
    for (int i = 0; i < 3; i++) begin
      pp[i]   = pm[i];
      pc[i]   = in_ch.ch;
      pp[i+3] = pw[i];
      pc[i+3] = CH_US;
      pp[i+6] = ps[i];
      pc[i+6] = CH_SEMI;
    end

    // compact the non-empty steps into one run
    n     = '0;
    steps = '0;
    for (int i = 0; i < NPRIM; i++) begin
      if (pp[i] != PRIM_NONE && n < (STEP_W+1)'(MAX_STEPS)) begin
        steps[n[STEP_W-1:0]] = prim_step(pp[i], pc[i]);
        n = n + 1'b1;
      end
    end
    if (in_ch.last && n < (STEP_W+1)'(MAX_STEPS)) begin
      steps[n[STEP_W-1:0]].kind  = KIND_DONE;
      steps[n[STEP_W-1:0]].ch    = 8'd0;
      steps[n[STEP_W-1:0]].ttype = 3'd0;
      n = n + 1'b1;
    end

    lex_state_nxt = lex_state_r;
    hold_nxt      = hold_r;
    push          = 1'b0;
    wentry.cnt    = n;
    wentry.steps  = steps;
    if (accept) begin
      if (hold_r) begin
        if (in_ch.last) begin
          hold_nxt      = 1'b0;
          lex_state_nxt = ST_START;
        end
      end else if (nx == NX_FORBID) begin
        push                = 1'b1;
        wentry.cnt          = (STEP_W+1)'(1);
        wentry.steps        = '0;
        wentry.steps[0].kind = KIND_ERROR;
        if (in_ch.last) begin
          hold_nxt      = 1'b0;
          lex_state_nxt = ST_START;
        end else begin
          hold_nxt      = 1'b1;
          lex_state_nxt = st;
        end
      end else begin
        push          = (n != '0);
        lex_state_nxt = in_ch.last ? ST_START : nx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lex_state_r <= ST_START;
      hold_r      <= 1'b0;
    end else begin
      lex_state_r <= lex_state_nxt;
      hold_r      <= hold_nxt;
    end
  end

endmodule

[hdl/mel_queue.sv]
module mel_queue
  import mel_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t wentry,
  output logic   full,
  input  logic   pop,
  output logic   q_valid,
  output entry_t q_entry
);

  entry_t mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full    = (count_r == (QPTR_W+1)'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_entry = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wentry;
    end
  end

endmodule

[hdl/mel_back.sv]
`include "math_expression_lexer_unit_assert.svh"

module mel_back
  import mel_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  entry_t   q_entry,
  output logic     q_pop,
  mel_out_if.source out_ch
);

  logic [STEP_W-1:0] idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  kind_t             kind_r;
  logic [7:0]        char_r;
  logic [2:0]        ttype_r;
  logic              lor_r;
  logic              load, is_end;
  step_t             step;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.out_char    = char_r;
  assign out_ch.token_type  = ttype_r;
  assign out_ch.last_of_run = lor_r;

  always_comb begin
    load    = q_valid && (!out_valid_r || out_ch.ready);
    step    = q_entry.steps[idx_r];
    is_end  = ({1'b0, idx_r} == q_entry.cnt - 1'b1);
    q_pop   = load && is_end;
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = is_end ? '0 : idx_r + 1'b1;
    end
    if (load)              out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
    else                   out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r  <= step.kind;
      char_r  <= step.ch;
      ttype_r <= step.ttype;
      lor_r   <= is_end;
    end
  end

  `MEL_ASSERT_IMP(a_idx_in_run, q_valid, ({1'b0, idx_r} < q_entry.cnt), "step index past run")
  `MEL_ASSERT_IMP(a_run_nonempty, q_valid, (q_entry.cnt != '0 && q_entry.cnt <= (STEP_W+1)'(MAX_STEPS)), "bad run length")
  `MEL_ASSERT_IMP(a_mid_run_held, (idx_r != '0), q_valid, "run lost while part sent")
  `MEL_ASSERT_IMP(a_final_closes, (out_valid_r && (kind_r == KIND_ERROR || kind_r == KIND_DONE)), lor_r, "error or done not last of run")
  `MEL_ASSERT_NXT(a_pop_restarts, q_pop, (idx_r == '0), "index not reset after run")

endmodule

[hdl/math_expression_lexer_unit.sv]
// channel   dir  payload                                   handshake
// in_ch     in   ch[7:0], last                             valid/ready
// out_ch    out  kind[1:0], out_char[7:0], token_type[2:0],
//                last_of_run                               valid/ready
//
// One character is classified and its whole result run built in the cycle it is taken.
// Runs wait in a four-entry queue ahead of a registered output, so new characters are
// taken while older runs drain. The back end sends one result per cycle while the output
// is not held by back-pressure; each item gives 0 to 8 results, usually 1 to 3.
// Input stalls only when the queue is full; the output register holds under back-pressure.
// Synchronous active-low reset clears lexer state, queue and output valid.
module math_expression_lexer_unit
  import mel_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  mel_in_if.sink    in_ch,
  mel_out_if.source out_ch
);

  logic   push, full, pop, q_valid;
  entry_t wentry, q_entry;

  mel_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (full),
    .push   (push),
    .wentry (wentry)
  );

  mel_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wentry  (wentry),
    .full    (full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_entry (q_entry)
  );

  mel_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule

[tb/tb_top.sv]
module tb_top;
  import mel_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 300;
  localparam int CALM_FROM = 255;
  localparam int PRINT_CAP = 40;

  localparam logic [2:0] NO_WAY = 3'd7;
  localparam logic [2:0] LAST_STATE = 3'd5;
  localparam logic [4:0] SEQ_FIRST = 5'd10;
  localparam logic [4:0] SEQ_LAST = 5'd23;
  localparam logic [3:0] PR_END = 4'd0;
  localparam logic [3:0] PR_APPEND = 4'd1;
  localparam logic [3:0] PR_CLOSE = 4'd2;

  typedef enum int {
    C_ALPHA, C_DIGIT, C_BLANK, C_DOT, C_OPEN, C_SHUT, C_ARITH, C_ASSIGN, C_SEMI, C_COMMA,
    C_BAD
  } chcls_e;

  typedef enum int {BY_MODEL, NO_RESULT, ONE_ERROR} row_exp_e;

  typedef struct {
    kind_t      kind;
    logic [7:0] ch;
    logic [2:0] ttype;
    logic       lor;
  } lex_res_t;

  typedef struct {
    logic [7:0] ch;
    logic       lst;
    row_exp_e   how;
  } plan_row_t;

  typedef logic [7:0] text_t[$];

  logic clk = 1'b0;
  logic rst_n;

  mel_in_if  in_if ();
  mel_out_if out_if ();

  math_expression_lexer_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  lex_res_t   due_results[$];
  lex_res_t   fresh_run[$];
  logic [2:0] lex_st = 3'd0;
  bit         err_held = 1'b0;
  int         errors = 0;
  bit         idle_en = 1'b1;
  bit         calm = 1'b0;
  int         stall_left = 0;
  int         quiet_cycles = 0;

  plan_row_t plan [26] = '{
    '{8'hFF, 1'b0, ONE_ERROR},
    '{"a",   1'b0, NO_RESULT},
    '{8'h00, 1'b1, NO_RESULT},
    '{" ",   1'b0, NO_RESULT},
    '{"x",   1'b0, BY_MODEL},
    '{"_",   1'b0, BY_MODEL},
    '{"=",   1'b0, BY_MODEL},
    '{"9",   1'b0, BY_MODEL},
    '{".",   1'b0, BY_MODEL},
    '{"0",   1'b0, BY_MODEL},
    '{"+",   1'b0, BY_MODEL},
    '{"(",   1'b0, BY_MODEL},
    '{"f",   1'b0, BY_MODEL},
    '{"(",   1'b0, BY_MODEL},
    '{"A",   1'b0, BY_MODEL},
    '{",",   1'b0, BY_MODEL},
    '{"-",   1'b0, BY_MODEL},
    '{"1",   1'b0, BY_MODEL},
    '{")",   1'b0, BY_MODEL},
    '{")",   1'b0, BY_MODEL},
    '{"/",   1'b0, BY_MODEL},
    '{"z",   1'b1, BY_MODEL},
    '{"y",   1'b0, BY_MODEL},
    '{"=",   1'b0, BY_MODEL},
    '{"7",   1'b1, BY_MODEL},
    '{"#",   1'b1, ONE_ERROR}
  };

  function automatic chcls_e sort_char(logic [7:0] c);
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_US) return C_ALPHA;
    if (c >= "0" && c <= "9") return C_DIGIT;
    if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) return C_BLANK;
    if (c == CH_DOT) return C_DOT;
    if (c == "(") return C_OPEN;
    if (c == ")") return C_SHUT;
    if (c == "+" || c == "-" || c == "*" || c == "/") return C_ARITH;
    if (c == CH_EQ) return C_ASSIGN;
    if (c == CH_SEMI) return C_SEMI;
    if (c == CH_COMMA) return C_COMMA;
    return C_BAD;
  endfunction

  function automatic logic [2:0] succ(chcls_e cls, int st);
    logic [0:5][2:0] row;
    case (cls)
      C_ALPHA:  row = {3'd0, 3'd2, 3'd2, 3'd7, 3'd2, 3'd7};
      C_DIGIT:  row = {3'd7, 3'd5, 3'd2, 3'd7, 3'd5, 3'd5};
      C_BLANK:  row = {3'd0, 3'd1, 3'd3, 3'd3, 3'd1, 3'd1};
      C_DOT:    row = {3'd7, 3'd5, 3'd7, 3'd7, 3'd5, 3'd5};
      C_OPEN:   row = {3'd7, 3'd1, 3'd1, 3'd1, 3'd1, 3'd7};
      C_SHUT:   row = {3'd7, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1};
      C_ARITH:  row = {3'd7, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4};
      C_ASSIGN: row = {3'd1, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7};
      C_SEMI:   row = {3'd7, 3'd0, 3'd0, 3'd0, 3'd7, 3'd0};
      C_COMMA:  row = {3'd7, 3'd1, 3'd1, 3'd7, 3'd7, 3'd1};
      default:  row = {6{NO_WAY}};
    endcase
    return row[st];
  endfunction

  function automatic logic [4:0] act(chcls_e cls, int st);
    logic [0:5][4:0] row;
    case (cls)
      C_ALPHA:  row = {5'd1, 5'd1,  5'd1,  5'd0,  5'd10, 5'd0};
      C_DIGIT:  row = {5'd0, 5'd1,  5'd1,  5'd0,  5'd10, 5'd1};
      C_BLANK:  row = {5'd0, 5'd0,  5'd0,  5'd0,  5'd5,  5'd4};
      C_DOT:    row = {5'd0, 5'd1,  5'd0,  5'd0,  5'd10, 5'd1};
      C_OPEN:   row = {5'd0, 5'd11, 5'd12, 5'd12, 5'd13, 5'd0};
      C_SHUT:   row = {5'd0, 5'd11, 5'd14, 5'd14, 5'd13, 5'd15};
      C_ARITH:  row = {5'd0, 5'd1,  5'd16, 5'd16, 5'd1,  5'd19};
      C_ASSIGN: row = {5'd6, 5'd0,  5'd0,  5'd0,  5'd0,  5'd0};
      C_SEMI:   row = {5'd0, 5'd17, 5'd18, 5'd18, 5'd0,  5'd20};
      C_COMMA:  row = {5'd0, 5'd21, 5'd22, 5'd0,  5'd0,  5'd23};
      default:  row = '0;
    endcase
    return row[st];
  endfunction

  function automatic logic [3:0] seq_step(int idx, int i);
    logic [0:2][3:0] row;
    case (idx)
      0:       row = {4'd5, 4'd1, 4'd0};
      1:       row = {4'd1, 4'd7, 4'd0};
      2:       row = {4'd2, 4'd1, 4'd7};
      3:       row = {4'd5, 4'd1, 4'd7};
      4:       row = {4'd3, 4'd1, 4'd7};
      5:       row = {4'd4, 4'd1, 4'd7};
      6:       row = {4'd3, 4'd1, 4'd0};
      7:       row = {4'd1, 4'd8, 4'd0};
      8:       row = {4'd3, 4'd1, 4'd8};
      9:       row = {4'd4, 4'd1, 4'd0};
      10:      row = {4'd4, 4'd1, 4'd8};
      11:      row = {4'd1, 4'd9, 4'd0};
      12:      row = {4'd3, 4'd1, 4'd9};
      default: row = {4'd4, 4'd1, 4'd9};
    endcase
    return row[i];
  endfunction

  function automatic void do_prim(logic [3:0] p, logic [7:0] c);
    if (fresh_run.size() >= MAX_STEPS) return;
    if (p == PR_APPEND) fresh_run.push_back('{KIND_APPEND, c, 3'd0, 1'b0});
    else if (p >= PR_CLOSE && p <= PR_CLOSE + 4'd7)
      fresh_run.push_back('{KIND_TOKEN_END, 8'h00, 3'(p - PR_CLOSE), 1'b0});
  endfunction

  function automatic void do_action(logic [4:0] code, logic [7:0] c);
    logic [3:0] p;
    if (code < SEQ_FIRST) begin
      do_prim(code[3:0], c);
    end else if (code <= SEQ_LAST) begin
      for (int i = 0; i < 3; i++) begin
        p = seq_step(int'(code - SEQ_FIRST), i);
        if (p == PR_END) break;
        do_prim(p, c);
      end
    end
  endfunction

  // fills fresh_run; returns 0 when the item is swallowed by a held error
  function automatic bit lex_char(logic [7:0] c, logic lst);
    int         st;
    chcls_e     cls;
    logic [2:0] nx;
    fresh_run.delete();
    st = (lex_st > LAST_STATE) ? 0 : int'(lex_st);
    if (err_held) begin
      if (lst) begin
        err_held = 1'b0;
        lex_st = 3'd0;
      end
      return 1'b0;
    end
    cls = sort_char(c);
    nx = (cls == C_BAD) ? NO_WAY : succ(cls, st);
    if (nx == NO_WAY) begin
      fresh_run.push_back('{KIND_ERROR, 8'h00, 3'd0, 1'b1});
      err_held = !lst;
      lex_st = lst ? 3'd0 : 3'(st);
      return 1'b1;
    end
    do_action(act(cls, st), c);
    st = int'(nx);
    if (lst) begin
      do_action(act(C_BLANK, st), CH_US);
      do_action(act(C_SEMI, st), CH_SEMI);
      if (fresh_run.size() < MAX_STEPS) fresh_run.push_back('{KIND_DONE, 8'h00, 3'd0, 1'b0});
      st = 0;
    end
    lex_st = 3'(st);
    if (fresh_run.size() > 0) fresh_run[fresh_run.size() - 1].lor = 1'b1;
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string what);
    if (errors < PRINT_CAP) $display("[%0t] %s", $time, what);
    errors++;
  endtask

  task automatic check_result();
    lex_res_t want;
    if (due_results.size() == 0) begin
      note_mismatch($sformatf("unexpected item kind %0d char %h type %0d last %0b",
                              out_if.kind, out_if.out_char, out_if.token_type,
                              out_if.last_of_run));
      return;
    end
    want = due_results.pop_front();
    if (out_if.kind !== want.kind || out_if.out_char !== want.ch ||
        out_if.token_type !== want.ttype || out_if.last_of_run !== want.lor)
      note_mismatch($sformatf("got kind %0d char %h type %0d last %0b, want %s %h %0d %0b",
                              out_if.kind, out_if.out_char, out_if.token_type,
                              out_if.last_of_run, want.kind.name(), want.ch, want.ttype,
                              want.lor));
  endtask

  task automatic push_item(input logic [7:0] c, input logic lst);
    if (idle_en && !calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.ch    <= c;
    in_if.last  <= lst;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic feed(input logic [7:0] c, input logic lst, input row_exp_e how);
    push_item(c, lst);
    void'(lex_char(c, lst));
    case (how)
      NO_RESULT: ;
      ONE_ERROR: due_results.push_back('{KIND_ERROR, 8'h00, 3'd0, 1'b1});
      default:   foreach (fresh_run[i]) due_results.push_back(fresh_run[i]);
    endcase
  endtask

  function automatic logic [7:0] any_alpha();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'(8'h61 + r);
    if (r < 52) return 8'(8'h41 + r - 26);
    return CH_US;
  endfunction

  function automatic logic [7:0] any_digit();
    return 8'(8'h30 + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] any_blank();
    case ($urandom_range(0, 3))
      0:       return 8'h09;
      1:       return 8'h0D;
      2:       return 8'h0A;
      default: return " ";
    endcase
  endfunction

  function automatic logic [7:0] any_arith();
    case ($urandom_range(0, 3))
      0:       return "+";
      1:       return "-";
      2:       return "*";
      default: return "/";
    endcase
  endfunction

  function automatic void add_blanks(ref text_t t);
    if ($urandom_range(0, 1) == 0) repeat ($urandom_range(1, 2)) t.push_back(any_blank());
  endfunction

  function automatic void add_word(ref text_t t);
    t.push_back(any_alpha());
    repeat ($urandom_range(0, 2)) t.push_back($urandom_range(0, 2) == 0 ? any_digit()
                                                                        : any_alpha());
  endfunction

  function automatic void add_leaf(ref text_t t);
    if ($urandom_range(0, 1) == 0) begin
      add_word(t);
    end else begin
      if ($urandom_range(0, 7) == 0) t.push_back(CH_DOT);
      repeat ($urandom_range(1, 3)) t.push_back(any_digit());
      if ($urandom_range(0, 2) == 0) begin
        t.push_back(CH_DOT);
        repeat ($urandom_range(1, 2)) t.push_back(any_digit());
      end
    end
  endfunction

  function automatic void add_operand(ref text_t t);
    int sel;
    sel = $urandom_range(0, 3);
    if (sel < 2) begin
      add_leaf(t);
    end else if (sel == 2) begin
      add_word(t);
      t.push_back("(");
      add_leaf(t);
      t.push_back(CH_COMMA);
      add_blanks(t);
      add_leaf(t);
      t.push_back(")");
    end else begin
      t.push_back("(");
      add_leaf(t);
      t.push_back(any_arith());
      add_leaf(t);
      t.push_back(")");
    end
  endfunction

  // mostly well-formed statements, some corrupted or cut short, some pure noise
  function automatic void make_statement(ref text_t t);
    int cut;
    t.delete();
    if ($urandom_range(0, 11) == 0) begin
      repeat ($urandom_range(1, 6)) t.push_back(8'($urandom_range(0, 255)));
      return;
    end
    add_word(t);
    add_blanks(t);
    t.push_back(CH_EQ);
    add_blanks(t);
    add_operand(t);
    repeat ($urandom_range(0, 3)) begin
      add_blanks(t);
      t.push_back(any_arith());
      add_blanks(t);
      add_operand(t);
    end
    if ($urandom_range(0, 2) == 0) t.push_back(CH_SEMI);
    if ($urandom_range(0, 3) == 0) t.push_back(any_blank());
    if ($urandom_range(0, 5) == 0) t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, t.size());
      while (t.size() > cut) void'(t.pop_back());
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) check_result();
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (idle_en && !calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("math_expression_lexer_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    text_t t;
    int    taken;
    int    waited;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.ch     = 8'h00;
    in_if.last   = 1'b0;
    taken        = 0;
    waited       = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) feed(plan[i].ch, plan[i].lst, plan[i].how);

    while (taken < RANDOM_ITEMS) begin
      make_statement(t);
      idle_en = ($urandom_range(0, 3) != 0);
      calm = (taken >= CALM_FROM);
      foreach (t[i]) begin
        feed(t[i], i == t.size() - 1, BY_MODEL);
        taken++;
      end
    end
    in_if.valid <= 1'b0;

    while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
    if (due_results.size() != 0)
      note_mismatch($sformatf("%0d expected items never arrived", due_results.size()));

    if (errors == 0) begin
      $display("math_expression_lexer_unit: match");
    end else begin
      $display("math_expression_lexer_unit: mismatch");
    end
    $finish;
  end

endmodule
